### hdl/rhs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhs_pkg: shared types and constants for the rgb to hue/saturation converter
// Holds the channel widths, the divider lane type and the max-channel codes.
// ----------------------------------------------------------------------------
package rhs_pkg;

  localparam int ChanW     = 8;   // width of one color channel and of each result
  localparam int QuotW     = 8;   // quotient bits, one per divider cell
  localparam int HueNumW   = 19;  // 255 * n, n below 6 * 255
  localparam int SatNumW   = 16;  // 255 * d
  localparam int SpanW     = 11;  // width of n and of 6 * d

  // which channel holds the maximum (red wins ties, then green)
  localparam logic [1:0] SEL_RED   = 2'd0;
  localparam logic [1:0] SEL_GREEN = 2'd1;
  localparam logic [1:0] SEL_BLUE  = 2'd2;

  // partial state of both divisions, handed from cell to cell
  typedef struct packed {
    logic [HueNumW-1:0] hue_rem;
    logic [HueNumW-1:0] hue_div;
    logic [QuotW-1:0]   hue_q;
    logic [SatNumW-1:0] sat_rem;
    logic [SatNumW-1:0] sat_div;
    logic [QuotW-1:0]   sat_q;
  } div_lane_t;

endpackage

### hdl/rhs_pixel_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhs_pixel_if: pixel input channel
// Carries one rgb pixel per transaction with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rhs_pixel_if import rhs_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] red;
  logic [ChanW-1:0] green;
  logic [ChanW-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

### hdl/rhs_hs_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhs_hs_if: hue/saturation output channel
// Carries one hue and saturation pair per transaction with valid/ready.
// ----------------------------------------------------------------------------
interface rhs_hs_if import rhs_pkg::*;;
  logic             valid;
  logic             ready;
  logic [ChanW-1:0] hue;
  logic [ChanW-1:0] saturation;

  modport source (output valid, output hue, output saturation, input ready);
  modport sink   (input valid, input hue, input saturation, output ready);
endinterface

### hdl/rhs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhs_front: two-stage front end of the converter
// Finds max, min and chroma, then forms the hue and saturation dividends
// and the pre-shifted divisors that seed the divider chain.
// ----------------------------------------------------------------------------
module rhs_front import rhs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [ChanW-1:0] red,
  input  logic [ChanW-1:0] green,
  input  logic [ChanW-1:0] blue,
  output logic             out_valid,
  output div_lane_t        lane
);

  // stage a registers
  logic             a_valid;
  logic [ChanW-1:0] a_red;
  logic [ChanW-1:0] a_green;
  logic [ChanW-1:0] a_blue;
  logic [ChanW-1:0] a_mx;
  logic [ChanW-1:0] a_d;
  logic [1:0]       a_sel;

  logic [ChanW-1:0] mx_next;
  logic [ChanW-1:0] mn_next;
  logic [1:0]       sel_next;

  logic [SpanW-1:0] six_d;
  logic [SpanW-1:0] n;
  div_lane_t        lane_next;

  // max, min and which channel is largest
  always_comb begin
    mx_next  = red;
    mn_next  = red;
    sel_next = SEL_RED;
    if (green > mx_next) begin
      mx_next  = green;
      sel_next = SEL_GREEN;
    end
    if (blue > mx_next) begin
      mx_next  = blue;
      sel_next = SEL_BLUE;
    end
    if (green < mn_next) mn_next = green;
    if (blue < mn_next)  mn_next = blue;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_red   <= red;
      a_green <= green;
      a_blue  <= blue;
      a_mx    <= mx_next;
      a_d     <= mx_next - mn_next;
      a_sel   <= sel_next;
    end
  end

  // hue numerator, kept in 0 .. 6d-1
  always_comb begin
    six_d = {1'b0, a_d, 2'b00} + {2'b00, a_d, 1'b0};
    case (a_sel)
      SEL_RED: begin
        if (a_green >= a_blue) n = {3'b000, a_green - a_blue};
        else                   n = six_d - {3'b000, a_blue - a_green};
      end
      SEL_GREEN: n = {2'b00, a_d, 1'b0} + {3'b000, a_blue} - {3'b000, a_red};
      SEL_BLUE:  n = {1'b0, a_d, 2'b00} + {3'b000, a_red} - {3'b000, a_green};
      default:   n = '0;
    endcase
  end

  // dividends are 255 * x; divisors start shifted up by the quotient width less one
  always_comb begin
    lane_next.hue_rem = {n, 8'b0} - {8'b0, n};
    lane_next.sat_rem = {a_d, 8'b0} - {8'b0, a_d};
    // grey pixel: zero dividend over a unit divisor gives a zero hue
    if (a_d == '0) lane_next.hue_div = HueNumW'(1) << (QuotW - 1);
    else           lane_next.hue_div = {1'b0, six_d, 7'b0};
    // black pixel: same trick gives a zero saturation
    if (a_mx == '0) lane_next.sat_div = SatNumW'(1) << (QuotW - 1);
    else            lane_next.sat_div = {1'b0, a_mx, 7'b0};
    lane_next.hue_q = '0;
    lane_next.sat_q = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) lane <= lane_next;
  end

endmodule

### hdl/rhs_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rhs_div_cell: one restoring-division step for hue and saturation
// Decides one quotient bit of each division, then halves the divisor.
// ----------------------------------------------------------------------------
module rhs_div_cell import rhs_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_valid,
  input  div_lane_t lane_in,
  output logic      out_valid,
  output div_lane_t lane_out
);

  logic      hue_fit;
  logic      sat_fit;
  div_lane_t lane_next;

  // compare, conditionally subtract, shift in the quotient bit
  always_comb begin
    hue_fit = lane_in.hue_rem >= lane_in.hue_div;
    sat_fit = lane_in.sat_rem >= lane_in.sat_div;
    lane_next.hue_rem = hue_fit ? lane_in.hue_rem - lane_in.hue_div : lane_in.hue_rem;
    lane_next.sat_rem = sat_fit ? lane_in.sat_rem - lane_in.sat_div : lane_in.sat_rem;
    lane_next.hue_div = lane_in.hue_div >> 1;
    lane_next.sat_div = lane_in.sat_div >> 1;
    lane_next.hue_q   = {lane_in.hue_q[QuotW-2:0], hue_fit};
    lane_next.sat_q   = {lane_in.sat_q[QuotW-2:0], sat_fit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) lane_out <= lane_next;
  end

endmodule

### hdl/rgb_to_hue_saturation_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hue_saturation_top: 8-bit rgb pixel to hue and saturation
// Front end plus a chain of eight division cells; the last cell is the
// output register.
//
//   channel  dir  fields                    handshake
//   pixel    in   red, green, blue (8 each)  valid / ready
//   result   out  hue, saturation (8 each)   valid / ready
//
// One pixel is accepted every clock while no result waits untaken; each passes two front-end
// stages, then one cell per quotient bit in the cell chain.
// Synchronous reset clears all valid bits; payload registers are not reset.
// When a result waits at the output and is not taken, the whole chain
// holds and pixel.ready drops until the result is taken.
// ----------------------------------------------------------------------------
module rgb_to_hue_saturation_top import rhs_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  rhs_pixel_if.sink    pixel,
  rhs_hs_if.source     result
);

  logic             en;
  logic             valid_chain [QuotW+1];
  div_lane_t        lane_chain  [QuotW+1];

  // the chain advances unless a finished result is still waiting
  assign en          = !result.valid || result.ready;
  assign pixel.ready = en;

  rhs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (pixel.valid),
    .red       (pixel.red),
    .green     (pixel.green),
    .blue      (pixel.blue),
    .out_valid (valid_chain[0]),
    .lane      (lane_chain[0])
  );

  // one cell per quotient bit, most significant first
  for (genvar i = 0; i < QuotW; i++) begin : g_cell
    rhs_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (valid_chain[i]),
      .lane_in   (lane_chain[i]),
      .out_valid (valid_chain[i+1]),
      .lane_out  (lane_chain[i+1])
    );
  end

  assign result.valid      = valid_chain[QuotW];
  assign result.hue        = lane_chain[QuotW].hue_q;
  assign result.saturation = lane_chain[QuotW].sat_q;

endmodule

### tb/tb_rgb_to_hue_saturation_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_to_hue_saturation_top: self-checking bench for the rgb to hue/sat block
// Drives corner pixels and then shaped random pixels through the pixel channel.
// Each accepted pixel is converted by an integer hue/saturation predictor.
// Results are compared in order against the predictions. Both channels stall
// at random, and the sender also drains the pipe completely from time to time.
// ----------------------------------------------------------------------------

// one expected or observed hue/saturation pair
typedef struct packed {
  logic [rhs_pkg::ChanW-1:0] hue;
  logic [rhs_pkg::ChanW-1:0] saturation;
} hs_pair_t;

// in-order scoreboard with an integer hue/saturation predictor
class hue_sat_scoreboard;
  hs_pair_t    expected_q[$];
  int unsigned mismatches;
  int unsigned compared;

  function new();
    mismatches = 0;
    compared   = 0;
  endfunction

  // exact integer conversion of one pixel
  function hs_pair_t convert_pixel(logic [rhs_pkg::ChanW-1:0] r,
                                   logic [rhs_pkg::ChanW-1:0] g,
                                   logic [rhs_pkg::ChanW-1:0] b);
    hs_pair_t    pair;
    logic [1:0]  sel;
    int unsigned rv, gv, bv, mx, mn, d, n;
    pair = '0;
    rv   = 32'(r);
    gv   = 32'(g);
    bv   = 32'(b);
    // strict compares keep red ahead of green, green ahead of blue on ties
    mx  = rv;
    sel = rhs_pkg::SEL_RED;
    if (gv > mx) begin
      mx  = gv;
      sel = rhs_pkg::SEL_GREEN;
    end
    if (bv > mx) begin
      mx  = bv;
      sel = rhs_pkg::SEL_BLUE;
    end
    mn = rv;
    if (gv < mn) mn = gv;
    if (bv < mn) mn = bv;
    d = mx - mn;
    // hue numerator lands in 0 .. 6d-1
    if (d != 0) begin
      case (sel)
        rhs_pkg::SEL_RED: begin
          n = (gv >= bv) ? gv - bv : 6 * d - (bv - gv);
        end
        rhs_pkg::SEL_GREEN: begin
          n = 2 * d + bv - rv;
        end
        default: begin
          n = 4 * d + rv - gv;
        end
      endcase
      pair.hue = 8'((255 * n) / (6 * d));
    end
    if (mx != 0) pair.saturation = 8'((255 * d) / mx);
    return pair;
  endfunction

  function void note_pixel(logic [rhs_pkg::ChanW-1:0] r,
                           logic [rhs_pkg::ChanW-1:0] g,
                           logic [rhs_pkg::ChanW-1:0] b);
    expected_q.push_back(convert_pixel(r, g, b));
  endfunction

  function int outstanding();
    return expected_q.size();
  endfunction

  // one line per mismatch
  task report_mismatch(string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task check_result(logic [rhs_pkg::ChanW-1:0] hue, logic [rhs_pkg::ChanW-1:0] sat);
    hs_pair_t want;
    if (expected_q.size() == 0) begin
      report_mismatch($sformatf("result hue=%0d sat=%0d with no pixel pending", hue, sat));
    end else begin
      want = expected_q.pop_front();
      compared++;
      if (hue !== want.hue)
        report_mismatch($sformatf("result %0d hue got %0d want %0d", compared, hue, want.hue));
      if (sat !== want.saturation)
        report_mismatch($sformatf("result %0d saturation got %0d want %0d",
                                  compared, sat, want.saturation));
    end
  endtask
endclass

module tb_rgb_to_hue_saturation_top;
  import rhs_pkg::*;

  localparam int RandomPixels = 550;
  localparam int CycleLimit   = 100000;
  localparam int DrainCycles  = 16;

  logic clk;
  logic rst;
  bit   steady;
  int   cycle_count;
  int   directed_sent;
  int   random_sent;
  int   drains;

  hue_sat_scoreboard hsv;

  rhs_pixel_if pix_if ();
  rhs_hs_if    hs_if ();

  rgb_to_hue_saturation_top u_top (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pix_if),
    .result (hs_if)
  );

  // 50 MHz clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // a gap with a chance of about 6 in 100, none during the steady stretch
  function automatic bit take_gap();
    return !steady && ($urandom_range(99) < 6);
  endfunction

  // result side back-pressure
  always @(negedge clk) begin
    hs_if.ready <= !take_gap();
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && hs_if.valid && hs_if.ready) hsv.check_result(hs_if.hue, hs_if.saturation);
  end

  // watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("watchdog: no finish after %0d cycles", CycleLimit);
    $display("Verification failed");
    $finish;
  end

  // one pixel transaction, entered and left at a falling edge
  task automatic send_pixel(input logic [ChanW-1:0] r, g, b);
    while (take_gap()) begin
      pix_if.valid <= 1'b0;
      @(negedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.red   <= r;
    pix_if.green <= g;
    pix_if.blue  <= b;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    hsv.note_pixel(r, g, b);
    @(negedge clk);
  endtask

  // hold the sender until every pending result has come out
  task automatic drain_results();
    pix_if.valid <= 1'b0;
    drains++;
    while (hsv.outstanding() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [ChanW-1:0] clamp_chan(int v);
    if (v < 0) return '0;
    if (v > 255) return '1;
    return v[ChanW-1:0];
  endfunction

  // random pixel with shapes aimed at ties, near-grey and extreme channels
  function automatic void shape_pixel(output logic [ChanW-1:0] r, g, b);
    int base;
    int kind;
    kind = $urandom_range(9);
    r    = 8'($urandom_range(255));
    g    = 8'($urandom_range(255));
    b    = 8'($urandom_range(255));
    case (kind)
      5: begin
        // near grey, chroma of a few steps
        base = $urandom_range(255);
        r    = clamp_chan(base + $urandom_range(4) - 2);
        g    = clamp_chan(base + $urandom_range(4) - 2);
        b    = clamp_chan(base + $urandom_range(4) - 2);
      end
      6: begin
        // two channels equal
        case ($urandom_range(2))
          0: g = r;
          1: b = g;
          default: b = r;
        endcase
      end
      7: begin
        // channels pinned to the rails
        if ($urandom_range(2) == 0) r = $urandom_range(1) ? 8'hff : 8'h00;
        if ($urandom_range(2) == 0) g = $urandom_range(1) ? 8'hff : 8'h00;
        if ($urandom_range(2) == 0) b = $urandom_range(1) ? 8'hff : 8'h00;
      end
      8: begin
        // dark pixels
        r = 8'($urandom_range(7));
        g = 8'($urandom_range(7));
        b = 8'($urandom_range(7));
      end
      9: begin
        // one channel at full scale
        case ($urandom_range(2))
          0: r = 8'hff;
          1: g = 8'hff;
          default: b = 8'hff;
        endcase
      end
      default: begin
      end
    endcase
  endfunction

  // corner pixels: grey, black, primaries, ties and hue wrap
  task automatic send_corners();
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'h80, 8'h80, 8'h80);
    send_pixel(8'h01, 8'h01, 8'h01);
    send_pixel(8'hff, 8'h00, 8'h00);
    send_pixel(8'h00, 8'hff, 8'h00);
    send_pixel(8'h00, 8'h00, 8'hff);
    send_pixel(8'hff, 8'hff, 8'h00);
    send_pixel(8'h00, 8'hff, 8'hff);
    send_pixel(8'hff, 8'h00, 8'hff);
    send_pixel(8'hff, 8'h00, 8'h01);
    send_pixel(8'hff, 8'h01, 8'h00);
    send_pixel(8'h01, 8'h00, 8'h00);
    send_pixel(8'h00, 8'h01, 8'h00);
    send_pixel(8'h00, 8'h00, 8'h01);
    send_pixel(8'hfe, 8'hff, 8'hff);
    send_pixel(8'hff, 8'hfe, 8'hfe);
    send_pixel(8'h7f, 8'h80, 8'hff);
    send_pixel(8'hff, 8'h80, 8'h00);
    send_pixel(8'h80, 8'hff, 8'h00);
    send_pixel(8'h00, 8'h80, 8'hff);
    send_pixel(8'haa, 8'h55, 8'hff);
    send_pixel(8'h55, 8'haa, 8'h00);
    directed_sent = 23;
  endtask

  // stimulus and end of run
  initial begin
    logic [ChanW-1:0] r, g, b;
    hsv           = new();
    rst           = 1'b1;
    steady        = 1'b0;
    directed_sent = 0;
    random_sent   = 0;
    drains        = 0;
    pix_if.valid  = 1'b0;
    pix_if.red    = '0;
    pix_if.green  = '0;
    pix_if.blue   = '0;
    hs_if.ready   = 1'b0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_corners();
    drain_results();

    for (int i = 0; i < RandomPixels; i++) begin
      steady = (i >= 180 && i < 330);
      if (i % 137 == 136) drain_results();
      shape_pixel(r, g, b);
      send_pixel(r, g, b);
      random_sent++;
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk);

    $display("covered %0d corner pixels (black, grey, primaries, ties, hue wrap) and %0d random",
             directed_sent, random_sent);
    $display("%0d results compared, %0d mismatches, %0d full drains of the pipe",
             hsv.compared, hsv.mismatches, drains);
    if (hsv.mismatches == 0 && hsv.outstanding() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/rhs_pkg.sv
hdl/rhs_pixel_if.sv
hdl/rhs_hs_if.sv
hdl/rhs_front.sv
hdl/rhs_div_cell.sv
hdl/rgb_to_hue_saturation_top.sv
tb/tb_rgb_to_hue_saturation_top.sv
